FILE: rtl/mrbf_pkg.sv
// package: types, constants and helper functions for the merkle branch fold unit
`default_nettype none
package mrbf_pkg;

    typedef struct packed {
        logic        cmd;
        logic [63:0] hash_word0;
        logic [63:0] hash_word1;
        logic [63:0] hash_word2;
        logic [63:0] hash_word3;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] root_word0;
        logic [63:0] root_word1;
        logic [63:0] root_word2;
        logic [63:0] root_word3;
    } t_out_item;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FOLD = 1'b1;

    typedef logic [31:0] t_word;
    typedef logic [255:0] t_state;
    typedef logic [511:0] t_block;

    // control from sequencer to round core
    typedef struct packed {
        logic start;
        logic use_iv;
    } t_core_ctl;

    localparam t_state IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_block PAD1 = {32'h80000000, 416'h0, 32'd0, 32'd512};

    function automatic t_word rk(input logic [5:0] i);
        t_word k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mrbf_round_core.sv
// shared sha-256 compression core, one round per cycle
`default_nettype none
module mrbf_round_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  mrbf_pkg::t_core_ctl    i_ctl,
    input  mrbf_pkg::t_state       i_chain,
    input  mrbf_pkg::t_block       i_block,
    output logic                   o_done,
    output mrbf_pkg::t_state       o_digest
);
    logic [15:0][31:0] r_w;
    logic [7:0][31:0]  r_v;
    logic [7:0][31:0]  r_h;
    logic [5:0]        r_rnd;
    logic              r_busy;
    logic              r_done;

    mrbf_pkg::t_word s0, s1, wn, t1, t2, a, e, w0;
    mrbf_pkg::t_state chain;

    always_comb begin
        chain = i_ctl.use_iv ? mrbf_pkg::IV : i_chain;
        w0 = r_w[15];
        s0 = mrbf_pkg::rotr(r_w[14], 7) ^ mrbf_pkg::rotr(r_w[14], 18) ^ (r_w[14] >> 3);
        s1 = mrbf_pkg::rotr(r_w[1], 17) ^ mrbf_pkg::rotr(r_w[1], 19) ^ (r_w[1] >> 10);
        wn = r_w[15] + s0 + r_w[6] + s1;
        a  = r_v[7];
        e  = r_v[3];
        t1 = r_v[0] + (mrbf_pkg::rotr(e, 6) ^ mrbf_pkg::rotr(e, 11) ^ mrbf_pkg::rotr(e, 25))
             + ((e & r_v[2]) ^ (~e & r_v[1])) + mrbf_pkg::rk(r_rnd) + w0;
        t2 = (mrbf_pkg::rotr(a, 2) ^ mrbf_pkg::rotr(a, 13) ^ mrbf_pkg::rotr(a, 22))
             + ((a & r_v[6]) ^ (a & r_v[5]) ^ (r_v[6] & r_v[5]));
        for (int i = 0; i < 8; i++) begin
            o_digest[32*i +: 32] = r_h[i] + r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_ctl.start) begin
            r_w <= i_block;
            r_v <= chain;
            r_h <= chain;
        end else if (r_busy) begin
            r_w <= {r_w[14:0], wn};
            r_v <= {t1 + t2, r_v[7], r_v[6], r_v[5], r_v[4] + t1, r_v[3], r_v[2], r_v[1]};
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/merkle_root_from_branch_fold_unit.sv
// top level: merkle branch fold with double sha-256 on a shared round core
//   channel | direction | handshake          | payload
//   in      | input     | i_valid / o_ready  | i_item (t_in_item)
//   out     | output    | o_valid / i_ready  | o_item (t_out_item)
// a load item runs no compression; a sibling item keeps the unit from taking the next
// item: three 64-round compressions on the one round core, each with a start and a
// done cycle, plus the emit step.
// a result waits in the output register; no item is taken while it waits unless the
// receiver takes the result in the same cycle.
// reset clears the running hash and all control.
`default_nettype none
module merkle_root_from_branch_fold_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  mrbf_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  wire                  i_ready,
    output mrbf_pkg::t_out_item  o_item
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_C1   = 5'b00010,
        S_C2   = 5'b00100,
        S_C3   = 5'b01000,
        S_EMIT = 5'b10000
    } t_state_e;

    t_state_e r_st, n_st;
    mrbf_pkg::t_state r_run, r_mid;
    logic [255:0] r_sib;
    logic r_last, r_go, n_go;
    logic r_ov;
    mrbf_pkg::t_out_item r_out;

    mrbf_pkg::t_core_ctl ctl;
    mrbf_pkg::t_state chain, digest;
    mrbf_pkg::t_block blk;
    logic done, acc;

    assign o_ready = (r_st == S_IDLE) && (!r_ov || i_ready);
    assign acc = i_valid && o_ready;

    always_comb begin
        n_st = r_st;
        n_go = 1'b0;
        ctl.start = r_go;
        ctl.use_iv = 1'b1;
        chain = r_mid;
        blk = {r_run, r_sib};
        case (r_st)
            S_IDLE: if (acc && i_item.cmd == mrbf_pkg::CMD_FOLD) begin
                n_st = S_C1;
                n_go = 1'b1;
            end
            S_C1: if (done) begin
                n_st = S_C2;
                n_go = 1'b1;
            end
            S_C2: begin
                ctl.use_iv = 1'b0;
                blk = mrbf_pkg::PAD1;
                if (done) begin
                    n_st = S_C3;
                    n_go = 1'b1;
                end
            end
            S_C3: begin
                blk = {r_mid, 32'h80000000, 192'h0, 32'd256};
                if (done) n_st = S_EMIT;
            end
            S_EMIT: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    mrbf_round_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_chain(chain),
        .i_block(blk), .o_done(done), .o_digest(digest)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_go  <= 1'b0;
            r_ov  <= 1'b0;
            r_run <= '0;
        end else begin
            r_st <= n_st;
            r_go <= n_go;
            if ((acc && i_item.cmd == mrbf_pkg::CMD_LOAD && i_item.last) ||
                (r_st == S_EMIT && r_last)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (acc) begin
                r_last <= i_item.last;
                if (i_item.cmd == mrbf_pkg::CMD_LOAD) begin
                    r_run <= {i_item.hash_word0, i_item.hash_word1,
                              i_item.hash_word2, i_item.hash_word3};
                    if (i_item.last) begin
                        r_out <= {i_item.hash_word0, i_item.hash_word1,
                                  i_item.hash_word2, i_item.hash_word3};
                    end
                end else begin
                    r_sib <= {i_item.hash_word0, i_item.hash_word1,
                              i_item.hash_word2, i_item.hash_word3};
                end
            end
            if (done && (r_st == S_C1 || r_st == S_C2)) r_mid <= digest;
            if (done && r_st == S_C3) r_run <= digest;
            if (r_st == S_EMIT && r_last) begin
                r_out <= r_run;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;
endmodule
`default_nettype wire

FILE: rtl/mrbf_checker.sv
// port-level checker for the merkle branch fold unit, bound to the top level
`default_nettype none
module mrbf_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_valid,
    input wire                 o_ready,
    input mrbf_pkg::t_in_item  i_item,
    input wire                 o_valid,
    input wire                 i_ready,
    input mrbf_pkg::t_out_item o_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item)) else $error("out item dropped");

    a_fold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_item.cmd |=> !o_ready) else $error("ready during fold");

    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_item.cmd && i_item.last |=> o_valid)
        else $error("load with last not emitted");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_item.last && !o_valid |=> !o_valid)
        else $error("unexpected item");
endmodule

bind merkle_root_from_branch_fold_unit mrbf_checker u_chk (.*);
`default_nettype wire
